// File: sv/assert_macros.svh
// Assertion macros for the Euler angle to rotation matrix checker.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, quiet during reset.
`define E2R_ASSERT_NOW(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication, quiet during reset.
`define E2R_ASSERT_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
// Next-cycle implication that also holds across reset.
`define E2R_ASSERT_RST(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) else $error(msg);
`endif

// File: sv/e2r_pkg.sv
// Shared constants, types and tables for the Euler angle to rotation matrix block.
// No dependencies.
package e2r_pkg;
  localparam int CORDIC_STAGES = 16;
  // prep, CORDIC stages, sign fix, three product stages
  localparam int DEPTH = CORDIC_STAGES + 5;

  typedef logic signed [15:0] ang_t;
  typedef logic signed [33:0] xy_t;
  typedef logic signed [31:0] z_t;
  typedef logic signed [15:0] q14_t;

  localparam logic signed [15:0] ANG_LIMIT = 16'sd25736;
  localparam z_t PI_Z      = 32'sd843314857;
  localparam z_t HALF_PI_Z = 32'sd421657428;
  localparam xy_t CORDIC_GAIN = 34'sd652032874;

  // atan(2^-i) in units of 2^-28 rad
  function automatic z_t atan_z(input int idx);
    z_t r;
    case (idx)
      0: r = 32'sd210828714;
      1: r = 32'sd124459457;
      2: r = 32'sd65760959;
      3: r = 32'sd33381290;
      4: r = 32'sd16755422;
      5: r = 32'sd8385879;
      6: r = 32'sd4193963;
      7: r = 32'sd2097109;
      8: r = 32'sd1048571;
      9: r = 32'sd524287;
      10: r = 32'sd262144;
      11: r = 32'sd131072;
      12: r = 32'sd65536;
      13: r = 32'sd32768;
      14: r = 32'sd16384;
      15: r = 32'sd8192;
      16: r = 32'sd4096;
      17: r = 32'sd2048;
      18: r = 32'sd1024;
      19: r = 32'sd512;
      20: r = 32'sd256;
      21: r = 32'sd128;
      22: r = 32'sd64;
      23: r = 32'sd32;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction
endpackage

// File: sv/e2r_cordic.sv
// Pipelined rotation-mode CORDIC: sine and cosine of one Q3.13 angle in Q2.30.
// Depends on e2r_pkg; stage enables come from the top-level pipeline control.
module e2r_cordic import e2r_pkg::*; (
  input  logic                     clk,
  input  logic [CORDIC_STAGES+1:0] en,
  input  ang_t                     angle,
  output xy_t                      cos_o,
  output xy_t                      sin_o
);
  xy_t  x_r [0:CORDIC_STAGES];
  xy_t  y_r [0:CORDIC_STAGES];
  z_t   z_r [0:CORDIC_STAGES];
  logic f_r [0:CORDIC_STAGES];
  xy_t  c_r, s_r;

  ang_t a_sat;
  z_t   z_full;

  // clamp to +-pi and fold into +-pi/2
  always_comb begin
    if (angle > ANG_LIMIT) begin
      a_sat = ANG_LIMIT;
    end else if (angle < -ANG_LIMIT) begin
      a_sat = -ANG_LIMIT;
    end else begin
      a_sat = angle;
    end
    z_full = {{1{a_sat[15]}}, a_sat, 15'd0};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r[0] <= CORDIC_GAIN;
      y_r[0] <= '0;
      if (z_full > HALF_PI_Z) begin
        z_r[0] <= z_full - PI_Z;
        f_r[0] <= 1'b1;
      end else if (z_full < -HALF_PI_Z) begin
        z_r[0] <= z_full + PI_Z;
        f_r[0] <= 1'b1;
      end else begin
        z_r[0] <= z_full;
        f_r[0] <= 1'b0;
      end
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam z_t ATAN_I = atan_z(i);
    xy_t dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        f_r[i+1] <= f_r[i];
        if (!z_r[i][31]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - ATAN_I;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + ATAN_I;
        end
      end
    end
  end

  // undo the half-turn fold
  always_ff @(posedge clk) begin
    if (en[CORDIC_STAGES+1]) begin
      c_r <= f_r[CORDIC_STAGES] ? -x_r[CORDIC_STAGES] : x_r[CORDIC_STAGES];
      s_r <= f_r[CORDIC_STAGES] ? -y_r[CORDIC_STAGES] : y_r[CORDIC_STAGES];
    end
  end

  assign cos_o = c_r;
  assign sin_o = s_r;
endmodule

// File: sv/e2r_dcm.sv
// Three-stage product pipeline: forms the nine matrix elements from sines and cosines.
// Depends on e2r_pkg; stage enables come from the top-level pipeline control.
module e2r_dcm import e2r_pkg::*; (
  input  logic       clk,
  input  logic [2:0] en,
  input  xy_t        cph,
  input  xy_t        sph,
  input  xy_t        cth,
  input  xy_t        sth,
  input  xy_t        cps,
  input  xy_t        sps,
  output q14_t       m00,
  output q14_t       m01,
  output q14_t       m02,
  output q14_t       m10,
  output q14_t       m11,
  output q14_t       m12,
  output q14_t       m20,
  output q14_t       m21,
  output q14_t       m22
);
  function automatic xy_t mul30(input xy_t a, input xy_t b);
    logic signed [67:0] p;
    p = a * b;
    p = (p + 68'sd536870912) >>> 30;
    return p[33:0];
  endfunction

  function automatic q14_t to_q14(input logic signed [34:0] v);
    logic signed [34:0] r;
    r = (v + 35'sd32768) >>> 16;
    if (r > 35'sd16384) begin
      r = 35'sd16384;
    end else if (r < -35'sd16384) begin
      r = -35'sd16384;
    end
    return r[15:0];
  endfunction

  xy_t ss_r, cs_r, p00_r, p01_r, p12_r, p22_r, a10_r, a11_r, a20_r, a21_r;
  xy_t cps_r, sps_r, sth_r, sth2_r;
  xy_t t10_r, t11_r, t20_r, t21_r;
  xy_t q00_r, q01_r, q12_r, q22_r, b10_r, b11_r, b20_r, b21_r;
  q14_t m00_r, m01_r, m02_r, m10_r, m11_r, m12_r, m20_r, m21_r, m22_r;

  // first products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ss_r  <= mul30(sph, sth);
      cs_r  <= mul30(cph, sth);
      p00_r <= mul30(cth, cps);
      p01_r <= mul30(cth, sps);
      p12_r <= mul30(sph, cth);
      p22_r <= mul30(cph, cth);
      a10_r <= mul30(cph, sps);
      a11_r <= mul30(cph, cps);
      a20_r <= mul30(sph, sps);
      a21_r <= mul30(sph, cps);
      cps_r <= cps;
      sps_r <= sps;
      sth_r <= sth;
    end
  end

  // triple products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      t10_r  <= mul30(ss_r, cps_r);
      t11_r  <= mul30(ss_r, sps_r);
      t20_r  <= mul30(cs_r, cps_r);
      t21_r  <= mul30(cs_r, sps_r);
      q00_r  <= p00_r;
      q01_r  <= p01_r;
      q12_r  <= p12_r;
      q22_r  <= p22_r;
      b10_r  <= a10_r;
      b11_r  <= a11_r;
      b20_r  <= a20_r;
      b21_r  <= a21_r;
      sth2_r <= sth_r;
    end
  end

  // sum, round to Q1.14 and saturate
  always_ff @(posedge clk) begin
    if (en[2]) begin
      m00_r <= to_q14(35'(q00_r));
      m01_r <= to_q14(35'(q01_r));
      m02_r <= to_q14(-35'(sth2_r));
      m10_r <= to_q14(35'(t10_r) - 35'(b10_r));
      m11_r <= to_q14(35'(b11_r) + 35'(t11_r));
      m12_r <= to_q14(35'(q12_r));
      m20_r <= to_q14(35'(b20_r) + 35'(t20_r));
      m21_r <= to_q14(35'(t21_r) - 35'(b21_r));
      m22_r <= to_q14(35'(q22_r));
    end
  end

  assign m00 = m00_r;
  assign m01 = m01_r;
  assign m02 = m02_r;
  assign m10 = m10_r;
  assign m11 = m11_r;
  assign m12 = m12_r;
  assign m20 = m20_r;
  assign m21 = m21_r;
  assign m22 = m22_r;
endmodule

// File: sv/euler_to_rotation_matrix.sv
// Top level: Euler angles (roll, pitch, yaw) to ZYX direction cosine matrix.
// Depends on e2r_pkg, e2r_cordic and e2r_dcm.
//
//   channel | handshake          | payload
//   in      | in_valid/in_stall  | in_roll_angle, in_pitch_angle, in_yaw_angle (Q3.13)
//   out     | out_valid/out_stall| out_m00 .. out_m22 (Q1.14)
//
// One request per cycle enters while in_stall is low; the stages are angle fold,
// one CORDIC stage per iteration, sign fix, two multiplier stages, rounding stage.
// Reset (rst_n, synchronous) clears only the stage valid bits.
// Each stage holds while its successor is full and stalled, so bubbles compress
// and in_stall rises only when every stage holds a request.
module euler_to_rotation_matrix import e2r_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  ang_t in_roll_angle,
  input  ang_t in_pitch_angle,
  input  ang_t in_yaw_angle,
  output logic out_valid,
  input  logic out_stall,
  output q14_t out_m00,
  output q14_t out_m01,
  output q14_t out_m02,
  output q14_t out_m10,
  output q14_t out_m11,
  output q14_t out_m12,
  output q14_t out_m20,
  output q14_t out_m21,
  output q14_t out_m22
);
  logic [DEPTH-1:0] v_r, v_nxt, en;
  xy_t cph, sph, cth, sth, cps, sps;

  // stage enable: load when empty or when the next stage moves
  always_comb begin
    en[DEPTH-1] = !v_r[DEPTH-1] || !out_stall;
    for (int k = DEPTH - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    for (int k = 0; k < DEPTH; k++) begin
      if (en[k]) begin
        v_nxt[k] = (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1];
      end else begin
        v_nxt[k] = v_r[k];
      end
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  e2r_cordic u_roll (
    .clk(clk), .en(en[CORDIC_STAGES+1:0]), .angle(in_roll_angle),
    .cos_o(cph), .sin_o(sph)
  );
  e2r_cordic u_pitch (
    .clk(clk), .en(en[CORDIC_STAGES+1:0]), .angle(in_pitch_angle),
    .cos_o(cth), .sin_o(sth)
  );
  e2r_cordic u_yaw (
    .clk(clk), .en(en[CORDIC_STAGES+1:0]), .angle(in_yaw_angle),
    .cos_o(cps), .sin_o(sps)
  );

  e2r_dcm u_dcm (
    .clk(clk), .en(en[DEPTH-1:DEPTH-3]),
    .cph(cph), .sph(sph), .cth(cth), .sth(sth), .cps(cps), .sps(sps),
    .m00(out_m00), .m01(out_m01), .m02(out_m02),
    .m10(out_m10), .m11(out_m11), .m12(out_m12),
    .m20(out_m20), .m21(out_m21), .m22(out_m22)
  );

  assign in_stall  = !en[0];
  assign out_valid = v_r[DEPTH-1];
endmodule

// File: sv/e2r_checker.sv
// Port-level checks for euler_to_rotation_matrix, bound to the top level.
// Depends on e2r_pkg and assert_macros.svh.
`include "assert_macros.svh"
module e2r_checker import e2r_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input q14_t out_m00,
  input q14_t out_m02,
  input q14_t out_m22
);
  // empty pipeline after reset
  `E2R_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "out_valid after reset")
  // a moving output never backs up the input
  `E2R_ASSERT_NOW(a_no_false_stall, !out_stall, !in_stall, "in_stall without output stall")
  // held result stays put, checked on out_m00
  `E2R_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(out_m00), "result lost")
  // elements m02 and m22 stay within unit range
  `E2R_ASSERT_NOW(a_range, out_valid,
    out_m02 <= 16'sd16384 && out_m02 >= -16'sd16384 &&
    out_m22 <= 16'sd16384 && out_m22 >= -16'sd16384, "element out of range")
endmodule

bind euler_to_rotation_matrix e2r_checker u_e2r_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_m00(out_m00), .out_m02(out_m02), .out_m22(out_m22)
);

// File: sim/tb.sv
// Testbench for euler_to_rotation_matrix: drives angle requests, predicts the rotation matrix.
// Depends on e2r_pkg and the euler_to_rotation_matrix RTL.
`timescale 1ns / 100ps
module tb;
  import e2r_pkg::*;

  localparam int STAGES = CORDIC_STAGES;
  localparam int NAT_ENTRIES = 24;
  localparam longint PI_U = 843314857;
  localparam longint HALF_PI_U = 421657428;
  localparam longint GAIN_U = 652032874;
  localparam int ANG_MAX = 25736;
  localparam int ONE_Q14 = 16384;

  typedef struct packed {
    q14_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } dcm_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ang_t in_roll_angle = '0, in_pitch_angle = '0, in_yaw_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  q14_t out_m00, out_m01, out_m02, out_m10, out_m11, out_m12, out_m20, out_m21, out_m22;

  dcm_t expected_dcm_q[$];
  int mismatch_cnt = 0;
  int matrix_cnt = 0;
  int request_cnt = 0;
  bit stall_free = 1'b0;

  euler_to_rotation_matrix DUT (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // arctangent of 2^-i in 2^-28 rad
  function automatic longint arctan_step(input int i);
    longint tbl[NAT_ENTRIES] = '{210828714, 124459457, 65760959, 33381290, 16755422,
      8385879, 4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
      16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};
    return tbl[i];
  endfunction

  // cosine and sine of a Q3.13 angle in Q2.30
  task automatic angle_sincos(input ang_t ang, output longint c, output longint s);
    longint a, z, x, y, dx, dy;
    bit flip;
    a = ang;
    flip = 1'b0;
    if (a > ANG_MAX) a = ANG_MAX;
    if (a < -ANG_MAX) a = -ANG_MAX;
    z = a * 32768;
    if (z > HALF_PI_U) begin
      z -= PI_U; flip = 1'b1;
    end else if (z < -HALF_PI_U) begin
      z += PI_U; flip = 1'b1;
    end
    x = GAIN_U;
    y = 0;
    for (int i = 0; i < STAGES && i < NAT_ENTRIES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_step(i);
      end else begin
        x += dx; y -= dy; z += arctan_step(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic q14_t round_q14(input longint v);
    longint r;
    r = (v + (64'sd1 <<< 15)) >>> 16;
    if (r > ONE_Q14) r = ONE_Q14;
    if (r < -ONE_Q14) r = -ONE_Q14;
    return q14_t'(r);
  endfunction

  // rotation matrix for one roll/pitch/yaw request
  task automatic predict_dcm(input ang_t roll, input ang_t pitch, input ang_t yaw,
                             output dcm_t m);
    longint cph, sph, cth, sth, cps, sps, ss, cs;
    angle_sincos(roll, cph, sph);
    angle_sincos(pitch, cth, sth);
    angle_sincos(yaw, cps, sps);
    ss = q30_mul(sph, sth);
    cs = q30_mul(cph, sth);
    m.m00 = round_q14(q30_mul(cth, cps));
    m.m01 = round_q14(q30_mul(cth, sps));
    m.m02 = round_q14(-sth);
    m.m10 = round_q14(-q30_mul(cph, sps) + q30_mul(ss, cps));
    m.m11 = round_q14(q30_mul(cph, cps) + q30_mul(ss, sps));
    m.m12 = round_q14(q30_mul(sph, cth));
    m.m20 = round_q14(q30_mul(sph, sps) + q30_mul(cs, cps));
    m.m21 = round_q14(-q30_mul(sph, cps) + q30_mul(cs, sps));
    m.m22 = round_q14(q30_mul(cph, cth));
  endtask

  // send one request after a random gap, hold until accepted
  task automatic send_angles(input ang_t roll, input ang_t pitch, input ang_t yaw);
    dcm_t m;
    int gap;
    gap = stall_free ? 0 : $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_roll_angle <= roll;
    in_pitch_angle <= pitch;
    in_yaw_angle <= yaw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_dcm(roll, pitch, yaw, m);
    expected_dcm_q.push_back(m);
    request_cnt++;
  endtask

  // back-pressure: a random stall run per result, sometimes none
  initial begin
    int hold;
    @(posedge clk);
    forever begin
      hold = stall_free ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) hold = 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // compare each accepted matrix with the oldest prediction
  always @(posedge clk) begin
    dcm_t got, exp_m;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_m00, out_m01, out_m02, out_m10, out_m11, out_m12, out_m20, out_m21,
              out_m22};
      matrix_cnt++;
      if (expected_dcm_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("ERROR: unexpected matrix %h", got);
      end else begin
        exp_m = expected_dcm_q.pop_front();
        for (int k = 0; k < 9; k++) begin
          if (got[k*16 +: 16] !== exp_m[k*16 +: 16]) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("ERROR: matrix %0d element %0d expected %0d got %0d", matrix_cnt,
                       8 - k, $signed(exp_m[k*16 +: 16]), $signed(got[k*16 +: 16]));
          end
        end
      end
    end
  end

  function automatic ang_t rand_angle();
    case ($urandom_range(0, 7))
      0: return ang_t'($urandom);
      1: return ($urandom_range(0, 1)) ? ang_t'(ANG_MAX) : ang_t'(-ANG_MAX);
      default: return ang_t'(int'($urandom_range(0, 2 * ANG_MAX)) - ANG_MAX);
    endcase
  endfunction

  // extremes, quadrant folds and out-of-range saturation
  task automatic test_directed();
    ang_t pts[9] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868,
                     16'sd12869, -16'sd12869, 16'sh7fff, 16'sh8000};
    foreach (pts[i]) send_angles(pts[i], pts[(i + 3) % 9], pts[(i + 5) % 9]);
    send_angles(16'sd25737, -16'sd25737, 16'sd1);
    send_angles(-16'sd1, 16'sh5555, 16'shaaaa);
    send_angles(16'sd12868, 16'sd12868, 16'sd12868);
  endtask

  // random requests with random gaps and stalls
  task automatic test_random(input int n);
    repeat (n) send_angles(rand_angle(), rand_angle(), rand_angle());
  endtask

  // full-rate burst, both sides idle-free
  task automatic test_back_to_back(input int n);
    stall_free = 1'b1;
    repeat (n) send_angles(rand_angle(), rand_angle(), rand_angle());
    stall_free = 1'b0;
  endtask

  initial begin
    int waited;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1100);
    test_back_to_back(200);
    test_random(140);
    in_valid <= 1'b0;
    // drain, then let the pipeline settle
    waited = 0;
    while (expected_dcm_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DEPTH + 10) @(posedge clk);
    $display("Covered %0d angle requests, %0d matrices checked, %0d mismatches.",
             request_cnt, matrix_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && expected_dcm_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // timeout
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
